// ===== sv/cpxlat_pkg.sv =====
// ----------------------------------------------------------------------------
// cpxlat_pkg: shared types and constants for the codepage translator
// Opcodes, controller states, command/status bundles and memory sizes.
// ----------------------------------------------------------------------------
package cpxlat_pkg;

  // Number of 256-entry pages held by the reverse memory
  localparam int PAGES = 38;

  localparam int FWD_DEPTH = 256;
  localparam int REV_DEPTH = PAGES * 256;
  localparam int REV_AW    = $clog2(REV_DEPTH);

  // Page bound as a 9-bit value so PAGES = 256 still compares correctly
  localparam logic [8:0] PAGE_LIMIT = 9'(PAGES);

  localparam logic [7:0]        FILL_CHAR    = 8'h5F;  // '_'
  localparam logic [7:0]        ENABLE_INDEX = 8'hFF;
  localparam logic [REV_AW-1:0] FILL_LAST    = REV_AW'(REV_DEPTH - 1);

  typedef enum logic [1:0] {
    OP_START_LOAD = 2'd0,
    OP_LOAD_ENTRY = 2'd1,
    OP_TO_UNICODE = 2'd2,
    OP_TO_LOCAL   = 2'd3
  } opcode_t;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic start_load;  // clear enable, restart fill counter
    logic load_entry;  // write forward entry, and reverse entry if its page is in range
    logic lookup;      // read both memories, capture item into stage 1
    logic fill_wr;     // write fill char at fill counter
    logic out_load;    // stage 1 -> output register
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic fill_last;   // fill counter at last reverse address
  } dp_status_t;

endpackage

// ===== sv/cpxlat_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpxlat_ctrl: translator controller
// Handshakes, pipeline occupancy and the reverse-memory fill sequencer.
// ----------------------------------------------------------------------------
module cpxlat_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             opcode,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cpxlat_pkg::ctl_cmd_t   cmd,
  input  cpxlat_pkg::dp_status_t status
);

  cpxlat_pkg::state_t  state;
  cpxlat_pkg::state_t  state_next;
  cpxlat_pkg::opcode_t op;

  logic s1_vld;
  logic s1_vld_next;
  logic out_vld;
  logic out_vld_next;
  logic accept;
  logic out_load;
  logic s1_free;
  logic is_lookup;

  assign op = cpxlat_pkg::opcode_t'(opcode);

  // Occupancy and handshake
  assign out_load  = s1_vld && (!out_vld || !out_stall);
  assign s1_free   = !s1_vld || out_load;
  assign in_stall  = (state == cpxlat_pkg::ST_FILL) || !s1_free;
  assign accept    = in_valid && !in_stall;
  assign is_lookup = (op == cpxlat_pkg::OP_TO_UNICODE) || (op == cpxlat_pkg::OP_TO_LOCAL);
  assign out_valid = out_vld;

  always_comb begin
    s1_vld_next = s1_vld;
    if (accept && is_lookup) begin
      s1_vld_next = 1'b1;
    end else if (out_load) begin
      s1_vld_next = 1'b0;
    end
  end

  always_comb begin
    out_vld_next = out_vld;
    if (out_load) begin
      out_vld_next = 1'b1;
    end else if (!out_stall) begin
      out_vld_next = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cpxlat_pkg::ST_IDLE: begin
        if (accept && (op == cpxlat_pkg::OP_START_LOAD)) begin
          state_next = cpxlat_pkg::ST_FILL;
        end
      end
      cpxlat_pkg::ST_FILL: begin
        if (status.fill_last) begin
          state_next = cpxlat_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.out_load = out_load;
    unique case (state)
      cpxlat_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            cpxlat_pkg::OP_START_LOAD: cmd.start_load = 1'b1;
            cpxlat_pkg::OP_LOAD_ENTRY: cmd.load_entry = 1'b1;
            cpxlat_pkg::OP_TO_UNICODE: cmd.lookup     = 1'b1;
            cpxlat_pkg::OP_TO_LOCAL:   cmd.lookup     = 1'b1;
          endcase
        end
      end
      cpxlat_pkg::ST_FILL: begin
        cmd.fill_wr = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cpxlat_pkg::ST_IDLE;
      s1_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      s1_vld  <= s1_vld_next;
      out_vld <= out_vld_next;
    end
  end

  // A start_load always enters the fill sequence
  a_start_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.start_load |=> (state == cpxlat_pkg::ST_FILL))
    else $error("start_load did not enter fill");

  // Fill runs until the last address is written
  a_fill_hold: assert property (@(posedge clk) disable iff (rst)
    (state == cpxlat_pkg::ST_FILL) && !status.fill_last |=> (state == cpxlat_pkg::ST_FILL))
    else $error("fill ended early");

  // Stage 1 is never overwritten while its item is still there
  a_s1_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_vld && !out_load |-> !cmd.lookup)
    else $error("stage 1 overrun");

  // An item moved to the output register is presented next cycle
  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_vld)
    else $error("output item lost");

endmodule

// ===== sv/cpxlat_datapath.sv =====
// ----------------------------------------------------------------------------
// cpxlat_datapath: translator memories and result path
// Forward table with valid bits, reverse memory, enable flag, fill counter,
// lookup stage and output register.
// ----------------------------------------------------------------------------
module cpxlat_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             opcode,
  input  logic [7:0]             entry_index,
  input  logic [7:0]             local_char,
  input  logic [15:0]            code_in,
  input  cpxlat_pkg::ctl_cmd_t   cmd,
  output cpxlat_pkg::dp_status_t status,
  output logic [15:0]            char_out
);

  logic [15:0] fwd_mem [cpxlat_pkg::FWD_DEPTH];
  logic [cpxlat_pkg::FWD_DEPTH-1:0] fwd_vld;
  logic [7:0]  rev_mem [cpxlat_pkg::REV_DEPTH];

  logic        enabled;
  logic [cpxlat_pkg::REV_AW-1:0] fill_cnt;

  logic        page_ok;
  logic [cpxlat_pkg::REV_AW-1:0] code_addr;
  logic        rev_we;
  logic [cpxlat_pkg::REV_AW-1:0] rev_waddr;
  logic [7:0]  rev_wdata;

  // Stage 1: registered memory reads plus item context
  logic [15:0] fwd_rd;
  logic        fwd_hit;
  logic [7:0]  rev_rd;
  logic        s1_local;
  logic        s1_en;
  logic        s1_page_ok;
  logic [7:0]  s1_low;
  logic [7:0]  s1_lc;
  logic [15:0] result;

  assign page_ok   = {1'b0, code_in[15:8]} < cpxlat_pkg::PAGE_LIMIT;
  assign code_addr = page_ok ? code_in[cpxlat_pkg::REV_AW-1:0] : '0;
  assign status.fill_last = (fill_cnt == cpxlat_pkg::FILL_LAST);

  // Enable flag
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
    end else if (cmd.start_load) begin
      enabled <= 1'b0;
    end else if (cmd.load_entry && (entry_index == cpxlat_pkg::ENABLE_INDEX)) begin
      enabled <= 1'b1;
    end
  end

  // Fill address counter
  always_ff @(posedge clk) begin
    if (rst || cmd.start_load) begin
      fill_cnt <= '0;
    end else if (cmd.fill_wr) begin
      fill_cnt <= fill_cnt + 1'b1;
    end
  end

  // Forward table valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= '0;
    end else if (cmd.load_entry) begin
      fwd_vld[entry_index] <= 1'b1;
    end
  end

  // Forward table
  always_ff @(posedge clk) begin
    if (cmd.load_entry) begin
      fwd_mem[entry_index] <= code_in;
    end
    if (cmd.lookup) begin
      fwd_rd  <= fwd_mem[local_char];
      fwd_hit <= fwd_vld[local_char];
    end
  end

  // Reverse memory write port: fill sweep or entry load
  always_comb begin
    rev_we    = 1'b0;
    rev_waddr = code_addr;
    rev_wdata = entry_index;
    if (cmd.fill_wr) begin
      rev_we    = 1'b1;
      rev_waddr = fill_cnt;
      rev_wdata = cpxlat_pkg::FILL_CHAR;
    end else if (cmd.load_entry && page_ok) begin
      rev_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[rev_waddr] <= rev_wdata;
    end
    if (cmd.lookup) begin
      rev_rd <= rev_mem[code_addr];
    end
  end

  // Item context for stage 1
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      s1_local   <= (cpxlat_pkg::opcode_t'(opcode) == cpxlat_pkg::OP_TO_LOCAL);
      s1_en      <= enabled;
      s1_page_ok <= page_ok;
      s1_low     <= code_in[7:0];
      s1_lc      <= local_char;
    end
  end

  // Result select
  always_comb begin
    if (s1_local) begin
      if (!s1_en) begin
        result = {8'h00, s1_low};
      end else if (s1_page_ok) begin
        result = {8'h00, rev_rd};
      end else begin
        result = {8'h00, cpxlat_pkg::FILL_CHAR};
      end
    end else begin
      if (!s1_en) begin
        result = {8'h00, s1_lc};
      end else if (fwd_hit) begin
        result = fwd_rd;
      end else begin
        result = 16'h0000;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      char_out <= result;
    end
  end

endmodule

// ===== sv/codepage_unicode_translator.sv =====
// ----------------------------------------------------------------------------
// codepage_unicode_translator: 8-bit codepage <-> 16-bit Unicode translator
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// A to_unicode or to_local item is accepted every cycle while in_stall is low;
// its result goes through the registered memory read of stage 1, then the
// output register, where it is presented until taken. load_entry returns
// nothing. start_load is followed by a fill of the reverse memory with '_',
// one address per cycle through its single write port, during which
// in_stall stays high. Results still in flight drain meanwhile.
// ----------------------------------------------------------------------------
module codepage_unicode_translator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  local_char,
  input  logic [15:0] code_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] char_out
);

  cpxlat_pkg::ctl_cmd_t   cmd;
  cpxlat_pkg::dp_status_t status;

  cpxlat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  cpxlat_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .entry_index (entry_index),
    .local_char  (local_char),
    .code_in     (code_in),
    .opcode      (opcode),
    .cmd         (cmd),
    .status      (status),
    .char_out    (char_out)
  );

endmodule

// ===== bench/codepage_unicode_translator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codepage_unicode_translator_tb: self-checking bench for the translator
// Feeds opcode items through the valid/stall input channel and checks every
// translated character against a behavioral copy of both tables. A short
// directed pass hits the edge cases, then randomized load/translate sessions
// run under three phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module codepage_unicode_translator_tb;

  localparam int ITEM_TARGET     = 1950;
  localparam int MAX_START_LOADS = 10;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int END_SETTLE      = 16;

  typedef struct {
    cpxlat_pkg::opcode_t op;
    logic [7:0]  idx;
    logic [7:0]  lchar;
    logic [15:0] code;
    bit          drain;  // hold this item until no result is outstanding
  } xlat_item_t;

  typedef struct {
    logic [15:0] value;
    cpxlat_pkg::opcode_t op;
    logic [15:0] arg;
  } char_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = 2'd0;
  logic [7:0]  entry_index = 8'd0;
  logic [7:0]  local_char = 8'd0;
  logic [15:0] code_in = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] char_out;

  codepage_unicode_translator DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .entry_index(entry_index),
    .local_char(local_char),
    .code_in(code_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .char_out(char_out)
  );

  always #1 clk = ~clk;

  // Shadow copy of the translator state
  logic [15:0] fwd_map [cpxlat_pkg::FWD_DEPTH];
  logic [7:0]  rev_map [cpxlat_pkg::REV_DEPTH];
  bit          xlat_on;

  xlat_item_t   pending_items[$];
  char_expect_t expected_chars[$];
  xlat_item_t   cur_item;
  char_expect_t got_expect;
  bit           drain_next;
  int           total_items;
  int           sent_count;
  int           sender_idle_pct;
  int           receiver_stall_pct;
  int           mismatch_count;
  int           cycle_count;

  initial begin
    foreach (fwd_map[a]) fwd_map[a] = 16'h0000;
    foreach (rev_map[a]) rev_map[a] = 8'h00;
    xlat_on            = 1'b0;
    drain_next         = 1'b0;
    total_items        = 0;
    sent_count         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    mismatch_count     = 0;
    cycle_count        = 0;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 200) $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Update the shadow tables for one accepted item; queue its result if any
  task automatic translate_item(input xlat_item_t it);
    logic [7:0]   pg;
    int unsigned  addr;
    char_expect_t e;
    pg   = it.code[15:8];
    addr = int'(pg) * 256 + int'(it.code[7:0]);
    e.op  = it.op;
    e.arg = (it.op == cpxlat_pkg::OP_TO_UNICODE) ? {8'h00, it.lchar} : it.code;
    case (it.op)
      cpxlat_pkg::OP_START_LOAD: begin
        xlat_on = 1'b0;
        foreach (rev_map[a]) rev_map[a] = cpxlat_pkg::FILL_CHAR;
      end
      cpxlat_pkg::OP_LOAD_ENTRY: begin
        fwd_map[it.idx] = it.code;
        if ({1'b0, pg} < cpxlat_pkg::PAGE_LIMIT) rev_map[addr] = it.idx;
        if (it.idx == cpxlat_pkg::ENABLE_INDEX) xlat_on = 1'b1;
      end
      cpxlat_pkg::OP_TO_UNICODE: begin
        e.value = xlat_on ? fwd_map[it.lchar] : {8'h00, it.lchar};
        expected_chars.push_back(e);
      end
      default: begin
        if (!xlat_on) e.value = {8'h00, it.code[7:0]};
        else if ({1'b0, pg} < cpxlat_pkg::PAGE_LIMIT) e.value = {8'h00, rev_map[addr]};
        else e.value = {8'h00, cpxlat_pkg::FILL_CHAR};
        expected_chars.push_back(e);
      end
    endcase
  endtask

  task automatic queue_item(input cpxlat_pkg::opcode_t op, input logic [7:0] idx,
                            input logic [7:0] lc, input logic [15:0] code);
    xlat_item_t it;
    it.op    = op;
    it.idx   = idx;
    it.lchar = lc;
    it.code  = code;
    it.drain = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(it);
  endtask

  // Stimulus: directed edge cases, then randomized load/translate sessions
  initial begin
    logic [15:0] loaded_codes[$];
    logic [7:0]  loaded_idx[$];
    logic [15:0] code;
    logic [7:0]  idx;
    logic [7:0]  lc;
    int          start_loads;
    int          n_loads;
    int          n_xlat;
    int          pick;

    // Translation off: zero-extend bytes, truncate codes
    queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), 8'h00, 16'($urandom));
    queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), 8'hFF, 16'($urandom));
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'h0000);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'hFFFF);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'hA55A);
    // Forward entry written before any clear survives start_load
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'h41, 8'($urandom), 16'h0041);
    queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), 8'h41, 16'($urandom));
    queue_item(cpxlat_pkg::OP_START_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'h00, 8'($urandom), 16'h0000);
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'h80, 8'($urandom), 16'h20AC);
    // duplicate code: later entry wins in the reverse table
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'h81, 8'($urandom), 16'h20AC);
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'h82, 8'($urandom), 16'h25FF);
    // pages past the limit only touch the forward table
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'h83, 8'($urandom), 16'h2600);
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'h84, 8'($urandom), 16'hFFFF);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'h20AC);
    queue_item(cpxlat_pkg::OP_LOAD_ENTRY, cpxlat_pkg::ENABLE_INDEX, 8'($urandom), 16'h00FF);
    drain_next = 1'b1;
    queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), 8'h80, 16'($urandom));
    queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), 8'h83, 16'($urandom));
    queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), 8'h41, 16'($urandom));
    queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), 8'h10, 16'($urandom));
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'h20AC);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'h25FF);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'h2600);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'hFFFF);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'h1234);
    queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), 16'h00FF);

    // Random sessions: optional clear, a run of loads, then lookups
    start_loads = 1;
    while (pending_items.size() < ITEM_TARGET) begin
      loaded_codes.delete();
      loaded_idx.delete();
      if (start_loads < MAX_START_LOADS && $urandom_range(0, 2) == 0) begin
        queue_item(cpxlat_pkg::OP_START_LOAD, 8'($urandom), 8'($urandom), 16'($urandom));
        start_loads++;
      end
      n_loads = ($urandom_range(0, 5) == 0) ? 256 : $urandom_range(4, 48);
      for (int i = 0; i < n_loads; i++) begin
        idx = (n_loads == 256) ? 8'(i) : 8'($urandom);
        // a short run usually ends on the enabling entry
        if (n_loads != 256 && i == n_loads - 1 && $urandom_range(0, 3) != 0)
          idx = cpxlat_pkg::ENABLE_INDEX;
        pick = $urandom_range(0, 7);
        if (pick == 0)
          code = {8'($urandom_range(cpxlat_pkg::PAGES, 255)), 8'($urandom)};
        else if (pick == 1 && loaded_codes.size() > 0)
          code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
        else
          code = {8'($urandom_range(0, cpxlat_pkg::PAGES - 1)), 8'($urandom)};
        loaded_codes.push_back(code);
        loaded_idx.push_back(idx);
        queue_item(cpxlat_pkg::OP_LOAD_ENTRY, idx, 8'($urandom), code);
      end
      n_xlat = $urandom_range(40, 140);
      for (int i = 0; i < n_xlat; i++) begin
        if ($urandom_range(0, 99) < 2) drain_next = 1'b1;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          // stray load in the middle of lookups
          queue_item(cpxlat_pkg::OP_LOAD_ENTRY, 8'($urandom), 8'($urandom), 16'($urandom));
        end else if (pick < 10) begin
          lc = ($urandom_range(0, 1) == 0)
               ? loaded_idx[$urandom_range(0, loaded_idx.size() - 1)] : 8'($urandom);
          queue_item(cpxlat_pkg::OP_TO_UNICODE, 8'($urandom), lc, 16'($urandom));
        end else begin
          case ($urandom_range(0, 3))
            0, 1: code = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
            2: code = {8'($urandom_range(0, cpxlat_pkg::PAGES - 1)), 8'($urandom)};
            default: code = 16'($urandom);
          endcase
          queue_item(cpxlat_pkg::OP_TO_LOCAL, 8'($urandom), 8'($urandom), code);
        end
      end
    end
    total_items = pending_items.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("codepage_unicode_translator_tb: PASS");
    end else begin
      $display("codepage_unicode_translator_tb: FAIL");
    end
    $finish;
  end

  // Driver: present items from the pending queue, with idle gaps by phase
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        translate_item(cur_item);
        sent_count++;
      end
      if (sent_count * 3 < total_items) begin
        sender_idle_pct    = 37;
        receiver_stall_pct = 66;
      end else if (sent_count * 3 < total_items * 2) begin
        sender_idle_pct    = 66;
        receiver_stall_pct = 37;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
            !(pending_items[0].drain && expected_chars.size() != 0)) begin
          cur_item = pending_items.pop_front();
          in_valid    <= 1'b1;
          opcode      <= cur_item.op;
          entry_index <= cur_item.idx;
          local_char  <= cur_item.lchar;
          code_in     <= cur_item.code;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("char_out %h with no result pending", char_out));
        end else begin
          got_expect = expected_chars.pop_front();
          if (char_out !== got_expect.value)
            report_mismatch($sformatf("%s of %h: char_out %h, want %h",
                                      got_expect.op.name(), got_expect.arg,
                                      char_out, got_expect.value));
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("codepage_unicode_translator_tb: FAIL");
      $finish;
    end
  end

endmodule
